// ----- sv/adler32_checksum_unit_top_assert.svh -----
// Assertion macros for the Adler-32 checksum unit.
// Included by the top level; each macro expects clk and rst_n in scope.
`ifndef ADLER32_CHECKSUM_UNIT_TOP_ASSERT_SVH
`define ADLER32_CHECKSUM_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define A32_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define A32_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/adler32_pkg.sv -----
// Shared types and constants for the Adler-32 checksum unit.
// No dependencies; imported by every module of the block.
package adler32_pkg;

  localparam logic [15:0] ADLER_MOD = 16'd65521;

  // Input beat layout: tdata holds start_of_message, data_byte,
  // other_checksum and other_length from the lowest bit up.
  localparam int unsigned IN_TDATA_W = 112;
  localparam int unsigned SOF_BIT    = 0;
  localparam int unsigned BYTE_LSB   = 1;
  localparam int unsigned OTHER_LSB  = 9;
  localparam int unsigned LEN_LSB    = 41;

  localparam int unsigned CK_W = 32;
  localparam logic [CK_W-1:0] CK_ALL_ONES = 32'hFFFF_FFFF;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_BYTE = 2'd0;
  localparam kind_t KIND_COMB = 2'd1;
  localparam kind_t KIND_ERR  = 2'd2;

  // One classified item as it travels through the queue.
  typedef struct packed {
    kind_t       kind;
    logic        sof;
    logic [7:0]  data_byte;
    logic [31:0] other_checksum;
    logic [15:0] len_rem;
  } item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

// ----- sv/adler32_front.sv -----
// Front end: accepts input beats, classifies them and reduces the combine
// length modulo 65521. Depends on adler32_pkg.
module adler32_front import adler32_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // sof, data_byte, other_checksum, other_length
  input  logic [0:0]            in_tuser,   // mode
  input  q_stat_t               q_stat,
  output logic                  q_push,
  output item_t                 q_wdata
);

  logic        s1_v_r;
  kind_t       s1_kind_r, s1_kind_nxt;
  logic        s1_sof_r;
  logic [7:0]  s1_byte_r;
  logic [31:0] s1_other_r;
  logic [27:0] s1_wsum_r, s1_wsum_nxt;
  logic [63:0] len;
  logic [16:0] x1;
  logic [16:0] x2;

  assign len       = in_tdata[LEN_LSB +: 64];
  assign in_tready = !s1_v_r || !q_stat.full;
  assign q_push    = s1_v_r && !q_stat.full;

  // 2^16 is 15 modulo 65521, so each 16-bit chunk is weighted by a power of 15.
  always_comb begin
    if (in_tuser[0] == 1'b0) begin
      s1_kind_nxt = KIND_BYTE;
    end else if (len[63]) begin
      s1_kind_nxt = KIND_ERR;
    end else begin
      s1_kind_nxt = KIND_COMB;
    end
    s1_wsum_nxt = 28'(len[15:0]) + 28'(len[31:16]) * 28'd15
                + 28'(len[47:32]) * 28'd225 + 28'(len[62:48]) * 28'd3375;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_kind_r  <= s1_kind_nxt;
      s1_sof_r   <= in_tdata[SOF_BIT];
      s1_byte_r  <= in_tdata[BYTE_LSB +: 8];
      s1_other_r <= in_tdata[OTHER_LSB +: 32];
      s1_wsum_r  <= s1_wsum_nxt;
    end
  end

  // Fold the weighted sum twice more, then one conditional subtraction.
  always_comb begin
    x1 = 17'(s1_wsum_r[15:0]) + 17'(s1_wsum_r[27:16]) * 17'd15;
    x2 = 17'(x1[15:0]) + (x1[16] ? 17'd15 : 17'd0);
    q_wdata.kind           = s1_kind_r;
    q_wdata.sof            = s1_sof_r;
    q_wdata.data_byte      = s1_byte_r;
    q_wdata.other_checksum = s1_other_r;
    if (x2 >= 17'(ADLER_MOD)) begin
      q_wdata.len_rem = 16'(x2 - 17'(ADLER_MOD));
    end else begin
      q_wdata.len_rem = x2[15:0];
    end
  end

endmodule

// ----- sv/adler32_fifo.sv -----
// Short queue of classified items between the front and back ends.
// Depends on adler32_pkg.
module adler32_fifo import adler32_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_push,
  input  item_t   q_wdata,
  input  logic    q_pop,
  output item_t   q_rdata,
  output q_stat_t q_stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_rdata      = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.valid = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !q_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

// ----- sv/adler32_back.sv -----
// Back end: holds the running sums, executes byte and combine items and
// drives the result register. Depends on adler32_pkg.
module adler32_back import adler32_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [CK_W-1:0] seed,
  input  logic            q_valid,
  input  item_t           q_rdata,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [CK_W-1:0] out_tdata,   // checksum
  output logic [0:0]      out_tuser    // length_error
);

  localparam logic [1:0] ST_ISSUE  = 2'd0;
  localparam logic [1:0] ST_FOLD   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [15:0]     sum_a_r, sum_a_nxt;
  logic [15:0]     sum_b_r, sum_b_nxt;
  logic [31:0]     prod_r, prod_nxt;
  logic [15:0]     rem_r, rem_nxt;
  logic [31:0]     oth_r, oth_nxt;
  logic [15:0]     t_r, t_nxt;
  logic            out_v_r;
  logic [CK_W-1:0] out_ck_r, out_ck_nxt;
  logic            out_err_r, out_err_nxt;
  logic            out_free;
  logic            emit;

  logic [15:0] eff_a, eff_b;
  logic [16:0] ba, bb;
  logic [19:0] t1;
  logic [16:0] t2;
  logic [17:0] ca, cb;
  logic [31:0] word;

  assign out_free   = !out_v_r || out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_ck_r;
  assign out_tuser  = out_err_r;

  // Datapath for the three kinds of work.
  always_comb begin
    eff_a = q_rdata.sof ? seed[15:0]  : sum_a_r;
    eff_b = q_rdata.sof ? seed[31:16] : sum_b_r;

    ba = 17'(eff_a) + 17'(q_rdata.data_byte);
    if (ba >= 17'(ADLER_MOD)) ba = ba - 17'(ADLER_MOD);
    bb = 17'(eff_b) + 17'(ba[15:0]);
    if (bb >= 17'(ADLER_MOD)) bb = bb - 17'(ADLER_MOD);

    // Product of remainder and sum A reduced with 2^16 == 15.
    t1 = 20'(prod_r[15:0]) + 20'(prod_r[31:16]) * 20'd15;
    t2 = 17'(t1[15:0]) + 17'(t1[19:16]) * 17'd15;
    t_nxt = (t2 >= 17'(ADLER_MOD)) ? 16'(t2 - 17'(ADLER_MOD)) : t2[15:0];

    ca = 18'(sum_a_r) + 18'(oth_r[15:0]) + 18'(ADLER_MOD) - 18'd1;
    if (ca >= 18'(ADLER_MOD)) ca = ca - 18'(ADLER_MOD);
    if (ca >= 18'(ADLER_MOD)) ca = ca - 18'(ADLER_MOD);
    cb = 18'(t_r) + 18'(sum_b_r) + 18'(oth_r[31:16]) + 18'(ADLER_MOD) - 18'(rem_r);
    if (cb >= 18'(ADLER_MOD) * 18'd2) cb = cb - 18'(ADLER_MOD) * 18'd2;
    if (cb >= 18'(ADLER_MOD)) cb = cb - 18'(ADLER_MOD);
    // Unreduced operands may carry sum A into bit 16; the word keeps that overlap.
    word = {cb[15:0], 16'h0000} | {15'h0000, ca[16:0]};
  end

  // Sequencing: bytes and errors finish at issue; combines also pass fold and finish.
  always_comb begin
    state_nxt   = state_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    prod_nxt    = prod_r;
    rem_nxt     = rem_r;
    oth_nxt     = oth_r;
    q_pop       = 1'b0;
    emit        = 1'b0;
    out_ck_nxt  = out_ck_r;
    out_err_nxt = out_err_r;
    case (state_r)
      ST_ISSUE: begin
        if (q_valid) begin
          case (q_rdata.kind)
            KIND_BYTE: begin
              if (out_free) begin
                q_pop       = 1'b1;
                emit        = 1'b1;
                sum_a_nxt   = ba[15:0];
                sum_b_nxt   = bb[15:0];
                out_ck_nxt  = {bb[15:0], ba[15:0]};
                out_err_nxt = 1'b0;
              end
            end
            KIND_ERR: begin
              if (out_free) begin
                q_pop       = 1'b1;
                emit        = 1'b1;
                sum_a_nxt   = eff_a;
                sum_b_nxt   = eff_b;
                out_ck_nxt  = CK_ALL_ONES;
                out_err_nxt = 1'b1;
              end
            end
            KIND_COMB: begin
              q_pop     = 1'b1;
              sum_a_nxt = eff_a;
              sum_b_nxt = eff_b;
              prod_nxt  = 32'(q_rdata.len_rem) * 32'(eff_a);
              rem_nxt   = q_rdata.len_rem;
              oth_nxt   = q_rdata.other_checksum;
              state_nxt = ST_FOLD;
            end
            default: begin
              state_nxt = ST_ISSUE;
            end
          endcase
        end
      end
      ST_FOLD: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          emit        = 1'b1;
          sum_a_nxt   = word[15:0];
          sum_b_nxt   = word[31:16];
          out_ck_nxt  = word;
          out_err_nxt = 1'b0;
          state_nxt   = ST_ISSUE;
        end
      end
      default: begin
        state_nxt = ST_ISSUE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ISSUE;
      sum_a_r <= 16'd1;
      sum_b_r <= 16'd0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    oth_r     <= oth_nxt;
    t_r       <= t_nxt;
    out_ck_r  <= out_ck_nxt;
    out_err_r <= out_err_nxt;
  end

endmodule

// ----- sv/adler32_checksum_unit_top.sv -----
// Adler-32 checksum unit: one beat in, one checksum beat out.
// Input beats are accepted when in_tvalid and in_tready are both high. tuser
// carries mode (0 adds data_byte, 1 combines with other_checksum over
// other_length bytes); start_of_message reloads the sums from the seed first.
// Every input beat yields exactly one output beat: checksum in out_tdata
// (sum B high, sum A low) and length_error in out_tuser.
// The seed is written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the unit is idle, as the block itself does not enforce this.
// Throughput: one byte beat per cycle while the output is not stalled; a combine
// beat holds the sum registers through its multiply, modular fold and final add
// steps, which depend serially on the running sums. A front stage reduces the
// length and a QUEUE_DEPTH-entry queue decouples it from the sum logic.
// Reset (rst_n low, synchronous) sets the seed to 1 and the sums to A=1,
// B=0, and empties the pipeline. When out_tready is low the result register
// holds its beat, the queue fills, and in_tready then drops.
// Depends on adler32_pkg, adler32_front, adler32_fifo, adler32_back.
module adler32_checksum_unit_top import adler32_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,    // start_of_message, data_byte,
                                             // other_checksum, other_length
  input  logic [0:0]            in_tuser,    // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [CK_W-1:0]       out_tdata,   // checksum
  output logic [0:0]            out_tuser,   // length_error
  input  logic                  cfg_wr_en,
  input  logic [CK_W-1:0]       cfg_wr_data
);

`include "adler32_checksum_unit_top_assert.svh"

  logic [CK_W-1:0] seed_r;
  logic            q_push;
  logic            q_pop;
  item_t           q_wdata;
  item_t           q_rdata;
  q_stat_t         q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd1;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  adler32_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  adler32_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_stat  (q_stat)
  );

  adler32_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed       (seed_r),
    .q_valid    (q_stat.valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `A32_ASSERT_IMP(ast_push_not_full, q_push, !q_stat.full, "push into full queue")
  `A32_ASSERT_IMP(ast_pop_not_empty, q_pop, q_stat.valid, "pop from empty queue")
  `A32_ASSERT_NXT(ast_push_holds, q_push && !q_pop, q_stat.valid, "pushed item lost")
  `A32_ASSERT_IMP(ast_err_ones, out_tvalid && out_tuser[0], out_tdata == CK_ALL_ONES,
                  "length error without all-ones checksum")

endmodule

// ----- verif/adler32_checksum_tb_pkg.sv -----
// Checksum tracker for the Adler-32 checksum unit testbench: mirrors the running
// sums, predicts one result beat per accepted input beat and checks the results.
// Depends on adler32_pkg.
`timescale 1ns / 1ps
package adler32_checksum_tb_pkg;
  import adler32_pkg::*;

  localparam bit MODE_BYTE    = 1'b0;
  localparam bit MODE_COMBINE = 1'b1;
  localparam logic [63:0] MOD64 = 64'(ADLER_MOD);

  typedef struct {
    logic [CK_W-1:0] checksum;
    logic            length_error;
  } checksum_beat_t;

  class checksum_tracker;
    logic [31:0]    seed;
    logic [15:0]    sum_a;
    logic [15:0]    sum_b;
    checksum_beat_t expected_beats[$];
    int             errors;

    function new();
      seed   = 32'd1;
      sum_a  = 16'd1;
      sum_b  = 16'd0;
      errors = 0;
    endfunction

    function void set_seed(logic [31:0] value);
      seed = value;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // Advances the mirrored sums by one accepted beat and queues its result.
    function void accept_item(bit mode, bit sof, logic [7:0] data_byte,
                              logic [31:0] other, logic [63:0] len);
      logic [63:0]    rem;
      logic [63:0]    a;
      logic [63:0]    b;
      logic [63:0]    word;
      checksum_beat_t beat;
      if (sof) begin
        sum_a = seed[15:0];
        sum_b = seed[31:16];
      end
      beat.length_error = 1'b0;
      if (mode == MODE_BYTE) begin
        a = 64'(sum_a) + 64'(data_byte);
        if (a >= MOD64) a -= MOD64;
        b = 64'(sum_b) + a;
        if (b >= MOD64) b -= MOD64;
        sum_a = a[15:0];
        sum_b = b[15:0];
        beat.checksum = {sum_b, sum_a};
      end else if (len[63]) begin
        // A negative length leaves the sums alone.
        beat.checksum     = CK_ALL_ONES;
        beat.length_error = 1'b1;
      end else begin
        rem = len % MOD64;
        a = 64'(sum_a) + 64'(other[15:0]) + MOD64 - 64'd1;
        b = (rem * 64'(sum_a)) % MOD64 + 64'(sum_b) + 64'(other[31:16]) + MOD64 - rem;
        if (a >= MOD64) a -= MOD64;
        if (a >= MOD64) a -= MOD64;
        if (b >= (MOD64 << 1)) b -= (MOD64 << 1);
        if (b >= MOD64) b -= MOD64;
        // Unreduced operands may leave A wider than 16 bits; it overlaps B here.
        word  = (a | (b << 16)) & 64'hFFFF_FFFF;
        sum_a = word[15:0];
        sum_b = word[31:16];
        beat.checksum = word[31:0];
      end
      expected_beats.push_back(beat);
    endfunction

    task check_beat(logic [CK_W-1:0] checksum, logic length_error);
      checksum_beat_t exp_beat;
      if (expected_beats.size() == 0) begin
        report($sformatf("result beat %h/%b with nothing expected", checksum, length_error));
      end else begin
        exp_beat = expected_beats.pop_front();
        if (checksum !== exp_beat.checksum) begin
          report($sformatf("checksum %h, expected %h", checksum, exp_beat.checksum));
        end
        if (length_error !== exp_beat.length_error) begin
          report($sformatf("length_error %b, expected %b", length_error,
                           exp_beat.length_error));
        end
      end
    endtask

    task check_drained();
      if (expected_beats.size() != 0) begin
        report($sformatf("%0d result beats never arrived", expected_beats.size()));
      end
    endtask
  endclass

endpackage

// ----- verif/adler32_checksum_unit_top_tb.sv -----
// Top-level testbench for the Adler-32 checksum unit: drives byte and combine
// beats with random gaps and stalls across several seeds and checks every result.
// Depends on adler32_pkg, adler32_checksum_tb_pkg and adler32_checksum_unit_top.
`timescale 1ns / 1ps
module adler32_checksum_unit_top_tb;
  import adler32_pkg::*;
  import adler32_checksum_tb_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;   // start_of_message, data_byte,
                                     // other_checksum, other_length
  logic [0:0]            in_tuser;   // mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [CK_W-1:0]       out_tdata;  // checksum
  logic [0:0]            out_tuser;  // length_error
  logic                  cfg_wr_en;
  logic [CK_W-1:0]       cfg_wr_data;

  checksum_tracker tracker;
  bit              allow_idle;
  int              stall_left;

  adler32_checksum_unit_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: check each beat and stall in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_beat(out_tdata, out_tuser[0]);
    end
    if (stall_left > 0) begin
      stall_left--;
    end else if (allow_idle && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    out_tready <= (stall_left == 0);
  end

  task automatic send_item(input bit mode, input bit sof, input logic [7:0] data_byte,
                           input logic [31:0] other, input logic [63:0] len);
    logic [IN_TDATA_W-1:0] beat;
    beat = '0;
    beat[SOF_BIT]          = sof;
    beat[BYTE_LSB +: 8]    = data_byte;
    beat[OTHER_LSB +: 32]  = other;
    beat[LEN_LSB +: 64]    = len;
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.accept_item(mode, sof, data_byte, other, len);
    if (allow_idle && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_other();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    return {16'($urandom_range(0, 65520)), 16'($urandom_range(0, 65520))};
  endfunction

  // Lengths lean towards small counts and multiples of the modulus, with
  // negative and extreme values mixed in.
  function automatic logic [63:0] pick_length();
    logic [63:0] v;
    int          sel;
    v   = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      v = 64'($urandom_range(0, 300));
    end else if (sel < 60) begin
      v = 64'($urandom_range(1, 2000)) * MOD64 - 64'd2 + 64'($urandom_range(0, 4));
    end else if (sel < 75) begin
      v[63] = 1'b0;
    end else if (sel < 90) begin
      v[63] = 1'b1;
    end else begin
      case ($urandom_range(0, 3))
        0: v = 64'd0;
        1: v = 64'h7FFF_FFFF_FFFF_FFFF;
        2: v = 64'h8000_0000_0000_0000;
        default: v = '1;
      endcase
    end
    return v;
  endfunction

  task automatic run_messages(input int count);
    int msg_left;
    bit sof;
    bit mode;
    msg_left = 0;
    for (int i = 0; i < count; i++) begin
      sof = 1'b0;
      if (msg_left == 0) begin
        sof      = 1'b1;
        msg_left = $urandom_range(1, 48);
      end else if ($urandom_range(0, 49) == 0) begin
        sof = 1'b1;  // stray restart in the middle of a message
      end
      msg_left--;
      mode = ($urandom_range(0, 6) == 0) ? MODE_COMBINE : MODE_BYTE;
      send_item(mode, sof, 8'($urandom), pick_other(), pick_length());
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic write_seed(input logic [31:0] value);
    while (tracker.pending() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_seed(value);
  endtask

  initial begin
    logic [31:0] seeds[4];
    tracker     = new();
    allow_idle  = 1'b1;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset seed.
    send_item(MODE_BYTE, 1'b0, 8'h00, 32'h0, 64'd0);
    send_item(MODE_BYTE, 1'b0, 8'hFF, 32'hFFFF_FFFF, '1);
    send_item(MODE_BYTE, 1'b1, 8'h80, 32'h0, 64'd0);
    send_item(MODE_COMBINE, 1'b0, 8'hFF, 32'h0000_0001, 64'd0);
    send_item(MODE_COMBINE, 1'b0, 8'h00, 32'h1234_5678, 64'd1);
    send_item(MODE_COMBINE, 1'b0, 8'h00, 32'h0BAD_0C0D, MOD64);
    send_item(MODE_COMBINE, 1'b0, 8'h00, 32'hFFF0_FFF0, MOD64 - 64'd1);
    send_item(MODE_COMBINE, 1'b0, 8'h00, 32'h0001_0001, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(MODE_COMBINE, 1'b0, 8'h00, 32'h0001_0001, '1);
    send_item(MODE_COMBINE, 1'b1, 8'h00, 32'h0001_0001, 64'h8000_0000_0000_0000);
    send_item(MODE_BYTE, 1'b0, 8'h5A, 32'h0, 64'd0);
    send_item(MODE_COMBINE, 1'b0, 8'h00, 32'hFFFF_FFFF, 64'd1000);
    send_item(MODE_COMBINE, 1'b0, 8'h00, 32'h0000_0000, 64'd5);
    send_item(MODE_COMBINE, 1'b0, 8'h00, 32'hFFFF_0000, MOD64 + 64'd1);
    send_item(MODE_BYTE, 1'b0, 8'hFF, 32'h0, 64'd0);
    in_tvalid <= 1'b0;

    seeds[0] = 32'h0000_0000;
    seeds[1] = 32'hFFFF_FFFF;
    seeds[2] = $urandom;
    seeds[3] = 32'h0000_0001;
    foreach (seeds[p]) begin
      write_seed(seeds[p]);
      // The closing phase runs with both sides flat out.
      allow_idle = (p != 3);
      run_messages(250);
    end

    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    tracker.check_drained();
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
